// ===== hdl/stbs_pkg.sv =====
// Shared types and constants for the sorted table binary search unit.
// Used by stbs_ctrl, stbs_datapath and sorted_table_binary_search_unit.
package stbs_pkg;

    // Field widths fixed by the stream and configuration interfaces.
    localparam int unsigned COUNT_W      = 11;
    localparam int unsigned INDEX_W      = 10;
    localparam int unsigned VALUE_W      = 32;
    localparam int unsigned POS_W        = 10;
    localparam int unsigned S_TDATA_W    = 48;
    localparam int unsigned M_TDATA_W    = 16;
    // Wide enough to compare any index or count with the largest table depth.
    localparam int unsigned CMP_W        = 17;
    localparam int unsigned DEFAULT_DEPTH = 1024;

    // Command codes carried in s_tuser.
    typedef enum logic {
        CMD_LOAD   = 1'b0,
        CMD_SEARCH = 1'b1
    } cmd_code_t;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PROBE,
        ST_COMPARE,
        ST_DONE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic write_entry;   // store the accepted load item in the table
        logic search_start;  // latch target and set up the search bounds
        logic probe_read;    // read the table at the middle of the range
        logic mark_miss;     // range is empty: record a not-found result
        logic compare_step;  // record a hit or narrow the bounds
        logic result_load;   // move the result into the output register
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic range_empty;   // lower bound has reached the upper bound
        logic hit;           // probed entry equals the target
        logic out_free;      // output register can take a result this cycle
    } dp_status_t;

endpackage

// ===== hdl/stbs_datapath.sv =====
// Datapath of the binary search unit: table memory, search bounds,
// compare logic, count register and the output register.
// Depends on stbs_pkg.
module stbs_datapath #(
    parameter int unsigned TABLE_DEPTH = stbs_pkg::DEFAULT_DEPTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  stbs_pkg::ctrl_cmd_t           cmd,
    output stbs_pkg::dp_status_t          status,
    input  logic                          cfg_wr_en,
    input  logic [stbs_pkg::COUNT_W-1:0]  cfg_wr_data,
    input  logic [stbs_pkg::INDEX_W-1:0]  in_index,
    input  logic [stbs_pkg::VALUE_W-1:0]  in_value,
    input  logic                          m_tready,
    output logic                          m_tvalid,
    output logic                          out_found,
    output logic [stbs_pkg::POS_W-1:0]    out_position
);
    import stbs_pkg::*;

    localparam int unsigned ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned BND_W  = $clog2(TABLE_DEPTH + 1);

    logic [VALUE_W-1:0]       table_mem [TABLE_DEPTH];
    logic [COUNT_W-1:0]       table_count_reg;
    logic signed [VALUE_W-1:0] target_reg;
    logic signed [VALUE_W-1:0] rd_data_reg;
    logic [BND_W-1:0]         lo_reg;
    logic [BND_W-1:0]         end_reg;
    logic [ADDR_W-1:0]        mid_reg;
    logic                     found_reg;
    logic [ADDR_W-1:0]        hit_pos_reg;
    logic                     m_valid_reg;
    logic                     m_found_reg;
    logic [POS_W-1:0]         m_pos_reg;

    logic [CMP_W-1:0]         index_wide;
    logic                     index_ok;
    logic [ADDR_W+INDEX_W-1:0] index_ext;
    logic [ADDR_W-1:0]        wr_addr;
    logic [CMP_W-1:0]         count_wide;
    logic [BND_W-1:0]         count_sat;
    logic [BND_W:0]           mid_sum;
    logic [ADDR_W-1:0]        mid;
    logic [BND_W-1:0]         mid_plus1;
    logic [BND_W-1:0]         mid_bnd;
    logic [POS_W+ADDR_W-1:0]  pos_ext;
    logic                     probe_lt;

    // Load address: ignore indexes at or beyond the table depth.
    assign index_wide = CMP_W'(in_index);
    assign index_ok   = index_wide < CMP_W'(TABLE_DEPTH);
    assign index_ext  = {{ADDR_W{1'b0}}, in_index};
    assign wr_addr    = index_ext[ADDR_W-1:0];

    // Entries in use, saturated to the table depth.
    assign count_wide = CMP_W'(table_count_reg);
    assign count_sat  = (count_wide > CMP_W'(TABLE_DEPTH)) ? BND_W'(TABLE_DEPTH)
                                                            : BND_W'(table_count_reg);

    // Middle of [lo, end-1], rounded down; only used while lo < end.
    assign mid_sum   = ({1'b0, lo_reg} + {1'b0, end_reg}) - (BND_W+1)'(1);
    assign mid       = ADDR_W'(mid_sum >> 1);
    assign mid_bnd   = BND_W'(mid_reg);
    assign mid_plus1 = mid_bnd + BND_W'(1);

    assign probe_lt  = rd_data_reg < target_reg;
    assign pos_ext   = {{POS_W{1'b0}}, hit_pos_reg};

    // Status back to the controller.
    assign status.range_empty = lo_reg >= end_reg;
    assign status.hit         = rd_data_reg == target_reg;
    assign status.out_free    = !m_valid_reg || m_tready;

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            table_count_reg <= '0;
        end else if (cfg_wr_en) begin
            table_count_reg <= cfg_wr_data;
        end
    end

    // Table memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (cmd.write_entry && index_ok) begin
            table_mem[wr_addr] <= in_value;
        end
        if (cmd.probe_read) begin
            rd_data_reg <= table_mem[mid];
        end
    end

    // Search bounds, target and the pending result.
    always_ff @(posedge aclk) begin
        if (cmd.search_start) begin
            target_reg <= in_value;
            lo_reg     <= '0;
            end_reg    <= count_sat;
        end
        if (cmd.probe_read) begin
            mid_reg <= mid;
        end
        if (cmd.mark_miss) begin
            found_reg   <= 1'b0;
            hit_pos_reg <= '0;
        end
        if (cmd.compare_step) begin
            if (rd_data_reg == target_reg) begin
                found_reg   <= 1'b1;
                hit_pos_reg <= mid_reg;
            end else if (probe_lt) begin
                lo_reg <= mid_plus1;
            end else begin
                end_reg <= mid_bnd;
            end
        end
    end

    // Output register: holds a result until the transfer completes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.result_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.result_load) begin
            m_found_reg <= found_reg;
            m_pos_reg   <= pos_ext[POS_W-1:0];
        end
    end

    assign m_tvalid     = m_valid_reg;
    assign out_found    = m_found_reg;
    assign out_position = m_pos_reg;

endmodule

// ===== hdl/stbs_ctrl.sv =====
// Controller state machine of the binary search unit.
// Sequences loads, probes and result hand-off; depends on stbs_pkg.
module stbs_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  in_command,
    output logic                  s_tready,
    input  stbs_pkg::dp_status_t  status,
    output stbs_pkg::ctrl_cmd_t   cmd
);
    import stbs_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign accept = s_tvalid && (state_reg == ST_IDLE);

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && (in_command == CMD_SEARCH)) begin
                    state_next = ST_PROBE;
                end
            end
            ST_PROBE: begin
                if (status.range_empty) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_COMPARE;
                end
            end
            ST_COMPARE: begin
                if (status.hit) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_PROBE;
                end
            end
            ST_DONE: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output logic: handshake and datapath commands.
    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready         = 1'b1;
                cmd.write_entry  = accept && (in_command == CMD_LOAD);
                cmd.search_start = accept && (in_command == CMD_SEARCH);
            end
            ST_PROBE: begin
                cmd.probe_read = !status.range_empty;
                cmd.mark_miss  = status.range_empty;
            end
            ST_COMPARE: begin
                cmd.compare_step = 1'b1;
            end
            ST_DONE: begin
                cmd.result_load = status.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== hdl/sorted_table_binary_search_unit.sv =====
// Sorted table binary search unit: top level joining controller and datapath.
// Depends on stbs_pkg, stbs_ctrl and stbs_datapath.
//
// The unit holds a table of TABLE_DEPTH signed 32-bit entries, loaded one entry per
// transfer (s_tuser = 0) and assumed sorted ascending; a load gives no result. A
// search transfer (s_tuser = 1) looks for s_tdata value in the first table_count
// entries (saturated to TABLE_DEPTH) and returns one result: m_tuser = found,
// m_tdata = index of the match, or 0 when not found. Each probe is one registered
// memory read followed by one compare; the result can be held by an output stall.
// A search makes at most floor(log2(count)) + 1 probes (up to 11 for 1024
// entries). One item is in work at a time; the next is accepted while a finished
// result waits in the output register. Only entries written since reset may be
// probed. Write table_count through cfg_wr_en / cfg_wr_data only while the unit
// is idle.
module sorted_table_binary_search_unit #(
    parameter int unsigned TABLE_DEPTH = stbs_pkg::DEFAULT_DEPTH
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Configuration: table_count.
    input  logic                            cfg_wr_en,
    input  logic [stbs_pkg::COUNT_W-1:0]    cfg_wr_data,
    // Input stream.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // Fields from bit 0: entry_index[9:0], value[41:10], zero fill[47:42].
    input  logic [stbs_pkg::S_TDATA_W-1:0]  s_tdata,
    // Fields from bit 0: command.
    input  logic                            s_tuser,
    // Result stream.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // Fields from bit 0: position[9:0], zero fill[15:10].
    output logic [stbs_pkg::M_TDATA_W-1:0]  m_tdata,
    // Fields from bit 0: found.
    output logic                            m_tuser
);
    import stbs_pkg::*;

    ctrl_cmd_t          cmd;
    dp_status_t         status;
    logic [INDEX_W-1:0] in_index;
    logic [VALUE_W-1:0] in_value;
    logic [POS_W-1:0]   out_position;

    // Unpack the input transfer.
    assign in_index = s_tdata[INDEX_W-1:0];
    assign in_value = s_tdata[INDEX_W+VALUE_W-1:INDEX_W];

    stbs_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .in_command (s_tuser),
        .s_tready   (s_tready),
        .status     (status),
        .cmd        (cmd)
    );

    stbs_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_index     (in_index),
        .in_value     (in_value),
        .m_tready     (m_tready),
        .m_tvalid     (m_tvalid),
        .out_found    (m_tuser),
        .out_position (out_position)
    );

    // Pack the result transfer.
    assign m_tdata = {{(M_TDATA_W-POS_W){1'b0}}, out_position};

endmodule
